[rtl/lesp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesp_pkg
// Holds the types and byte codes that the log escape sequence parser modules share.
// ----------------------------------------------------------------------------
package lesp_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SEQ  = 2'd2
  } parse_mode_t;

  typedef enum logic [2:0] {
    EV_TEXT      = 3'd0,
    EV_LINE_END  = 3'd1,
    EV_NEST_OPEN = 3'd2,
    EV_NEST_CLOSE = 3'd3,
    EV_UNDERFLOW = 3'd4
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  text;
    logic        header;
    logic [15:0] prio;
    logic [31:0] line;
    logic [31:0] column;
    logic        last;
  } result_t;

  localparam logic [7:0] CH_NL       = 8'h0a;
  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_SEMI     = 8'h3b;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7f;
  localparam logic [7:0] CH_TILDE    = 8'h7e;
  localparam logic [7:0] CH_P        = 8'h70;
  localparam logic [7:0] CH_Q        = 8'h71;
  localparam logic [7:0] CH_S        = 8'h73;
  localparam logic [7:0] CH_A        = 8'h61;
  localparam logic [7:0] CH_B        = 8'h62;

endpackage

[rtl/lesp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesp_core
// Holds the parser state and decodes one byte into up to two result events.
// ----------------------------------------------------------------------------
module lesp_core #(
  parameter int DEPTH_BITS    = 8,
  parameter int PRIORITY_BITS = 16,
  parameter int COUNTER_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          byte_in,
  input  logic                fire,
  output lesp_pkg::result_t   res [2],
  output logic [1:0]          res_count
);

  lesp_pkg::parse_mode_t      mode_r, mode_nxt;
  logic                       line_has_text_r, line_has_text_nxt;
  logic                       header_flag_r, header_flag_nxt;
  logic [DEPTH_BITS-1:0]      nest_depth_r, nest_depth_nxt;
  logic [PRIORITY_BITS-1:0]   cur_prio_r, cur_prio_nxt;
  logic                       suppress_nl_r, suppress_nl_nxt;
  logic [PRIORITY_BITS-1:0]   first_param_r, first_param_nxt;
  logic                       param_seen_r, param_seen_nxt;
  logic                       past_first_r, past_first_nxt;
  logic [COUNTER_BITS-1:0]    line_cnt_r, line_cnt_nxt;
  logic [COUNTER_BITS-1:0]    col_cnt_r, col_cnt_nxt;

  logic [PRIORITY_BITS+3:0]   accum;
  logic [PRIORITY_BITS-1:0]   seq_prio;
  logic [63:0]                prio_wide, line_wide, col_wide;
  logic                       is_final;
  logic                       end_first;
  logic                       slot;

  always_comb begin
    accum = ({4'b0, first_param_r} << 3) + ({4'b0, first_param_r} << 1)
          + (PRIORITY_BITS+4)'(byte_in - lesp_pkg::CH_ZERO);
    seq_prio  = param_seen_r ? first_param_r : PRIORITY_BITS'(1);
    prio_wide = 64'(cur_prio_r);
    is_final  = byte_in >= lesp_pkg::FINAL_LO && byte_in <= lesp_pkg::FINAL_HI &&
                byte_in != lesp_pkg::CH_TILDE;
  end

  always_comb begin
    mode_nxt = lesp_pkg::MODE_TEXT;
    unique case (mode_r)
      lesp_pkg::MODE_ESC: begin
        if (byte_in == lesp_pkg::CH_LBRACKET) mode_nxt = lesp_pkg::MODE_SEQ;
      end
      lesp_pkg::MODE_SEQ: begin
        if (!is_final) mode_nxt = lesp_pkg::MODE_SEQ;
      end
      default: begin
        if (byte_in == lesp_pkg::CH_ESC) mode_nxt = lesp_pkg::MODE_ESC;
      end
    endcase
  end

  always_comb begin
    line_has_text_nxt = line_has_text_r;
    header_flag_nxt   = header_flag_r;
    nest_depth_nxt    = nest_depth_r;
    cur_prio_nxt      = cur_prio_r;
    suppress_nl_nxt   = suppress_nl_r;
    first_param_nxt   = first_param_r;
    param_seen_nxt    = param_seen_r;
    past_first_nxt    = past_first_r;
    line_cnt_nxt      = line_cnt_r;
    col_cnt_nxt       = col_cnt_r;
    res[0]            = '0;
    res[1]            = '0;
    res_count         = 2'd0;
    end_first         = 1'b0;
    slot              = 1'b0;

    if (byte_in == lesp_pkg::CH_NL) begin
      if (line_cnt_r != '1) line_cnt_nxt = line_cnt_r + 1'b1;
      col_cnt_nxt = '0;
    end else if (col_cnt_r != '1) begin
      col_cnt_nxt = col_cnt_r + 1'b1;
    end
    line_wide = 64'(line_cnt_nxt);
    col_wide  = 64'(col_cnt_nxt);

    unique case (mode_r)
      lesp_pkg::MODE_ESC: begin
        if (byte_in == lesp_pkg::CH_LBRACKET) begin
          first_param_nxt = '0;
          param_seen_nxt  = 1'b0;
          past_first_nxt  = 1'b0;
        end
      end
      lesp_pkg::MODE_SEQ: begin
        if (is_final) begin
          end_first = line_has_text_r && (byte_in == lesp_pkg::CH_P ||
                      byte_in == lesp_pkg::CH_Q || byte_in == lesp_pkg::CH_S);
          if (end_first) begin
            res[0].kind       = lesp_pkg::EV_LINE_END;
            res[0].header     = header_flag_r;
            res[0].prio       = prio_wide[15:0];
            res_count         = 2'd1;
            slot              = 1'b1;
            line_has_text_nxt = 1'b0;
            header_flag_nxt   = 1'b0;
            cur_prio_nxt      = PRIORITY_BITS'(1);
          end
          if (byte_in == lesp_pkg::CH_P) begin
            res[slot].kind  = lesp_pkg::EV_NEST_OPEN;
            res_count       = res_count + 2'd1;
            if (nest_depth_r != '1) nest_depth_nxt = nest_depth_r + 1'b1;
            header_flag_nxt = 1'b1;
            cur_prio_nxt    = seq_prio;
          end else if (byte_in == lesp_pkg::CH_Q) begin
            res_count = res_count + 2'd1;
            if (nest_depth_r != '0) begin
              nest_depth_nxt = nest_depth_r - 1'b1;
              res[slot].kind = lesp_pkg::EV_NEST_CLOSE;
            end else begin
              res[slot].kind   = lesp_pkg::EV_UNDERFLOW;
              res[slot].line   = line_wide[31:0];
              res[slot].column = col_wide[31:0];
            end
          end else if (byte_in == lesp_pkg::CH_S) begin
            cur_prio_nxt = seq_prio;
          end else if (byte_in == lesp_pkg::CH_A) begin
            suppress_nl_nxt = 1'b1;
          end else if (byte_in == lesp_pkg::CH_B) begin
            suppress_nl_nxt = 1'b0;
          end
        end else if (byte_in >= lesp_pkg::CH_ZERO && byte_in <= lesp_pkg::CH_NINE) begin
          if (!past_first_r) begin
            if (accum[PRIORITY_BITS+3:PRIORITY_BITS] != '0) begin
              first_param_nxt = '1;
            end else begin
              first_param_nxt = accum[PRIORITY_BITS-1:0];
            end
            param_seen_nxt = 1'b1;
          end
        end else if (byte_in == lesp_pkg::CH_SEMI) begin
          past_first_nxt = 1'b1;
        end
      end
      default: begin
        if (byte_in == lesp_pkg::CH_NL && !suppress_nl_r) begin
          res[0].kind       = lesp_pkg::EV_LINE_END;
          res[0].header     = header_flag_r;
          res[0].prio       = prio_wide[15:0];
          res_count         = 2'd1;
          line_has_text_nxt = 1'b0;
          header_flag_nxt   = 1'b0;
          cur_prio_nxt      = PRIORITY_BITS'(1);
        end else if (byte_in != lesp_pkg::CH_ESC) begin
          res[0].kind       = lesp_pkg::EV_TEXT;
          res[0].text       = byte_in;
          res_count         = 2'd1;
          line_has_text_nxt = 1'b1;
        end
      end
    endcase

    if (res_count == 2'd2) begin
      res[1].last = 1'b1;
    end else if (res_count == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= lesp_pkg::MODE_TEXT;
      line_has_text_r <= 1'b0;
      header_flag_r   <= 1'b0;
      nest_depth_r    <= '0;
      cur_prio_r      <= PRIORITY_BITS'(1);
      suppress_nl_r   <= 1'b0;
      first_param_r   <= '0;
      param_seen_r    <= 1'b0;
      past_first_r    <= 1'b0;
      line_cnt_r      <= COUNTER_BITS'(1);
      col_cnt_r       <= '0;
    end else if (fire) begin
      mode_r          <= mode_nxt;
      line_has_text_r <= line_has_text_nxt;
      header_flag_r   <= header_flag_nxt;
      nest_depth_r    <= nest_depth_nxt;
      cur_prio_r      <= cur_prio_nxt;
      suppress_nl_r   <= suppress_nl_nxt;
      first_param_r   <= first_param_nxt;
      param_seen_r    <= param_seen_nxt;
      past_first_r    <= past_first_nxt;
      line_cnt_r      <= line_cnt_nxt;
      col_cnt_r       <= col_cnt_nxt;
    end
  end

endmodule

[rtl/log_escape_sequence_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_escape_sequence_parser
// Parses ESC [ control sequences in a log byte stream into text, line and
// nesting events.
//
// The input channel carries one log byte per transfer on in_byte_in. The
// result channel carries one event per transfer; a byte causes zero, one or
// two events, and out_last_of_run marks the final event of a byte.
// An accepted byte is held in an input register and decoded once the result
// queue has room for all of its events; those events are then registered
// into the result queue, from which the first event of a byte is offered.
// One byte is accepted per cycle while the decode stage is not held. The
// result queue holds two entries and drains one event per cycle while the
// receiver is ready, so a byte that causes two events can hold back the next.
// Reset clears the parser state, the line count to one and empties the
// input register and the result queue.
// When the receiver stalls, the result queue fills, the decode stage stops
// and in_ready falls once the input register is occupied.
// ----------------------------------------------------------------------------
module log_escape_sequence_parser #(
  parameter int DEPTH_BITS    = 8,
  parameter int PRIORITY_BITS = 16,
  parameter int COUNTER_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [7:0]  out_text_byte,
  output logic        out_header_line,
  output logic [15:0] out_line_priority,
  output logic [31:0] out_line_number,
  output logic [31:0] out_char_number,
  output logic        out_last_of_run
);

  logic                in_valid_r;
  logic [7:0]          in_byte_r;
  lesp_pkg::result_t   res [2];
  logic [1:0]          res_count;
  logic                fire;
  logic                pop;
  lesp_pkg::result_t   queue_r [2];
  lesp_pkg::result_t   queue_nxt [2];
  logic [1:0]          cnt_r, cnt_nxt, cnt_pop;

  lesp_core #(
    .DEPTH_BITS   (DEPTH_BITS),
    .PRIORITY_BITS(PRIORITY_BITS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_in  (in_byte_r),
    .fire     (fire),
    .res      (res),
    .res_count(res_count)
  );

  assign fire      = in_valid_r && ({1'b0, cnt_pop} + {1'b0, res_count} <= 3'd2);
  assign in_ready  = !in_valid_r || fire;
  assign out_valid = cnt_r != 2'd0;
  assign pop       = out_valid && out_ready;

  assign out_event_kind    = queue_r[0].kind;
  assign out_text_byte     = queue_r[0].text;
  assign out_header_line   = queue_r[0].header;
  assign out_line_priority = queue_r[0].prio;
  assign out_line_number   = queue_r[0].line;
  assign out_char_number   = queue_r[0].column;
  assign out_last_of_run   = queue_r[0].last;

  always_comb begin
    queue_nxt = queue_r;
    cnt_pop   = cnt_r - {1'b0, pop};
    if (pop) begin
      queue_nxt[0] = queue_r[1];
    end
    if (fire && res_count != 2'd0) begin
      if (cnt_pop == 2'd0) begin
        queue_nxt[0] = res[0];
        queue_nxt[1] = res[1];
      end else begin
        queue_nxt[1] = res[0];
      end
    end
    cnt_nxt = cnt_pop + (fire ? res_count : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    queue_r <= queue_nxt;
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte_in;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("Result queue count out of range.");

  a_pair_queued: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> cnt_r == 2'd2)
    else $error("A non-final event is shown without its follower queued.");

  a_pair_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_count == 2'd2 |=> cnt_r == 2'd2)
    else $error("Two events of one byte were not both queued.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> cnt_r == 2'd0 && !in_valid_r)
    else $error("Reset did not empty the pipeline.");

endmodule

[bench/tb_log_escape_sequence_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_escape_sequence_parser
// Checks the escape sequence parser event by event against a predictor of its
// parse state. A directed opening covers the special cases. Random log
// traffic follows, made of text runs, line ends and control sequences, with
// changing idle patterns on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_log_escape_sequence_parser;

  class event_scoreboard;
    lesp_pkg::parse_mode_t mode;
    bit                    has_text;
    bit                    header;
    bit                    suppress_nl;
    bit                    param_seen;
    bit                    past_param;
    logic [7:0]            depth;
    logic [15:0]           prio;
    logic [15:0]           param;
    logic [31:0]           line_cnt;
    logic [31:0]           col_cnt;
    lesp_pkg::result_t     predicted_events[$];
    int                    mismatches;

    function new();
      mode        = lesp_pkg::MODE_TEXT;
      has_text    = 1'b0;
      header      = 1'b0;
      suppress_nl = 1'b0;
      param_seen  = 1'b0;
      past_param  = 1'b0;
      depth       = '0;
      prio        = 16'd1;
      param       = '0;
      line_cnt    = 32'd1;
      col_cnt     = '0;
      mismatches  = 0;
    endfunction

    function lesp_pkg::result_t make_event(lesp_pkg::event_kind_t kind, logic [7:0] text,
                                           logic hdr, logic [15:0] p, logic [31:0] ln,
                                           logic [31:0] col);
      lesp_pkg::result_t r;
      r.kind   = kind;
      r.text   = text;
      r.header = hdr;
      r.prio   = p;
      r.line   = ln;
      r.column = col;
      r.last   = 1'b0;
      return r;
    endfunction

    function lesp_pkg::result_t close_line();
      lesp_pkg::result_t r;
      r        = make_event(lesp_pkg::EV_LINE_END, 8'h00, header, prio, '0, '0);
      has_text = 1'b0;
      header   = 1'b0;
      prio     = 16'd1;
      return r;
    endfunction

    function void predict_byte(logic [7:0] b);
      lesp_pkg::result_t evs[$];
      int unsigned       next_param;
      logic [15:0]       seq_prio;
      if (b == lesp_pkg::CH_NL) begin
        if (line_cnt != '1) line_cnt++;
        col_cnt = '0;
      end else if (col_cnt != '1) begin
        col_cnt++;
      end
      case (mode)
        lesp_pkg::MODE_ESC: begin
          if (b == lesp_pkg::CH_LBRACKET) begin
            mode       = lesp_pkg::MODE_SEQ;
            param      = '0;
            param_seen = 1'b0;
            past_param = 1'b0;
          end else begin
            mode = lesp_pkg::MODE_TEXT;
          end
        end
        lesp_pkg::MODE_SEQ: begin
          if (b >= lesp_pkg::FINAL_LO && b <= lesp_pkg::FINAL_HI &&
              b != lesp_pkg::CH_TILDE) begin
            seq_prio = param_seen ? param : 16'd1;
            mode     = lesp_pkg::MODE_TEXT;
            if ((b == lesp_pkg::CH_P || b == lesp_pkg::CH_Q || b == lesp_pkg::CH_S) &&
                has_text) begin
              evs = {evs, close_line()};
            end
            if (b == lesp_pkg::CH_P) begin
              evs = {evs, make_event(lesp_pkg::EV_NEST_OPEN, 8'h00, 1'b0, '0, '0, '0)};
              if (depth != '1) depth++;
              header = 1'b1;
              prio   = seq_prio;
            end else if (b == lesp_pkg::CH_Q) begin
              if (depth != '0) begin
                depth--;
                evs = {evs, make_event(lesp_pkg::EV_NEST_CLOSE, 8'h00, 1'b0, '0, '0, '0)};
              end else begin
                evs = {evs, make_event(lesp_pkg::EV_UNDERFLOW, 8'h00, 1'b0, '0,
                                       line_cnt, col_cnt)};
              end
            end else if (b == lesp_pkg::CH_S) begin
              prio = seq_prio;
            end else if (b == lesp_pkg::CH_A) begin
              suppress_nl = 1'b1;
            end else if (b == lesp_pkg::CH_B) begin
              suppress_nl = 1'b0;
            end
          end else if (b >= lesp_pkg::CH_ZERO && b <= lesp_pkg::CH_NINE) begin
            if (!past_param) begin
              next_param = param * 10 + (b - lesp_pkg::CH_ZERO);
              param      = (next_param > 65535) ? 16'hffff : next_param[15:0];
              param_seen = 1'b1;
            end
          end else if (b == lesp_pkg::CH_SEMI) begin
            past_param = 1'b1;
          end
        end
        default: begin
          mode = lesp_pkg::MODE_TEXT;
          if (b == lesp_pkg::CH_ESC) begin
            mode = lesp_pkg::MODE_ESC;
          end else if (b == lesp_pkg::CH_NL && !suppress_nl) begin
            evs = {evs, close_line()};
          end else begin
            evs = {evs, make_event(lesp_pkg::EV_TEXT, b, 1'b0, '0, '0, '0)};
            has_text = 1'b1;
          end
        end
      endcase
      if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
      foreach (evs[i]) predicted_events = {predicted_events, evs[i]};
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    function void compare_event(lesp_pkg::result_t got);
      lesp_pkg::result_t exp;
      if (predicted_events.size() == 0) begin
        report($sformatf("unexpected event kind=%0d text=%02h", got.kind, got.text));
        return;
      end
      exp = predicted_events.pop_front();
      if (got.kind !== exp.kind || got.text !== exp.text || got.header !== exp.header ||
          got.prio !== exp.prio || got.line !== exp.line || got.column !== exp.column ||
          got.last !== exp.last) begin
        report($sformatf({"event mismatch: expected kind=%0d text=%02h hdr=%0b prio=%0d ",
                          "line=%0d col=%0d last=%0b, actual kind=%0d text=%02h hdr=%0b ",
                          "prio=%0d line=%0d col=%0d last=%0b"},
                         exp.kind, exp.text, exp.header, exp.prio, exp.line, exp.column,
                         exp.last, got.kind, got.text, got.header, got.prio, got.line,
                         got.column, got.last));
      end
    endfunction

    function int outstanding();
      return predicted_events.size();
    endfunction
  endclass

  localparam int HOLD_OFF_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte_in;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_event_kind;
  logic [7:0]  out_text_byte;
  logic        out_header_line;
  logic [15:0] out_line_priority;
  logic [31:0] out_line_number;
  logic [31:0] out_char_number;
  logic        out_last_of_run;

  event_scoreboard board = new();
  int              src_idle_pct;
  int              snk_idle_pct;
  int              hold_off_reqs;
  int              bytes_sent;
  logic [7:0]      directed_bytes[$];

  log_escape_sequence_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_text_byte    (out_text_byte),
    .out_header_line  (out_header_line),
    .out_line_priority(out_line_priority),
    .out_line_number  (out_line_number),
    .out_char_number  (out_char_number),
    .out_last_of_run  (out_last_of_run)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    int hold_off_done;
    hold_off_done = 0;
    out_ready     = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_reqs != hold_off_done) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done++;
      end else begin
        out_ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    lesp_pkg::result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind   = lesp_pkg::event_kind_t'(out_event_kind);
      got.text   = out_text_byte;
      got.header = out_header_line;
      got.prio   = out_line_priority;
      got.line   = out_line_number;
      got.column = out_char_number;
      got.last   = out_last_of_run;
      board.compare_event(got);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_byte_in = b;
    do @(posedge clk); while (!in_ready);
    board.predict_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] sequence_noise();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while ((b >= lesp_pkg::FINAL_LO && b <= lesp_pkg::FINAL_HI && b != lesp_pkg::CH_TILDE) ||
           (b >= lesp_pkg::CH_ZERO && b <= lesp_pkg::CH_NINE) || b == lesp_pkg::CH_SEMI);
    return b;
  endfunction

  task automatic send_digits(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 10) send_byte(sequence_noise());
      send_byte(lesp_pkg::CH_ZERO + 8'($urandom_range(9)));
    end
  endtask

  task automatic send_sequence();
    int         pick;
    logic [7:0] fin;
    send_byte(lesp_pkg::CH_ESC);
    send_byte(lesp_pkg::CH_LBRACKET);
    send_digits($urandom_range(0, 6));
    if ($urandom_range(99) < 30) begin
      send_byte(lesp_pkg::CH_SEMI);
      send_digits($urandom_range(0, 3));
    end
    if ($urandom_range(99) < 10) send_byte(sequence_noise());
    pick = $urandom_range(99);
    if (pick < 20) fin = lesp_pkg::CH_P;
    else if (pick < 40) fin = lesp_pkg::CH_Q;
    else if (pick < 56) fin = lesp_pkg::CH_S;
    else if (pick < 68) fin = lesp_pkg::CH_A;
    else if (pick < 80) fin = lesp_pkg::CH_B;
    else begin
      do fin = 8'($urandom_range(8'h40, 8'h7f));
      while (fin == lesp_pkg::CH_TILDE);
    end
    send_byte(fin);
  endtask

  task automatic send_chunk();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 35) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(99) < 80) begin
          b = 8'($urandom_range(8'h20, 8'h7e));
        end else begin
          do b = 8'($urandom_range(255));
          while (b == lesp_pkg::CH_ESC || b == lesp_pkg::CH_NL);
        end
        send_byte(b);
      end
    end else if (pick < 45) begin
      send_byte(lesp_pkg::CH_NL);
    end else if (pick < 85) begin
      send_sequence();
    end else if (pick < 95) begin
      send_byte(lesp_pkg::CH_ESC);
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic run_random_phase(input int src_pct, input int snk_pct, input int count);
    int start;
    start        = bytes_sent;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (bytes_sent - start < count) send_chunk();
  endtask

  task automatic send_nest_run(input logic [7:0] fin, input int count);
    repeat (count) begin
      send_byte(lesp_pkg::CH_ESC);
      send_byte(lesp_pkg::CH_LBRACKET);
      send_byte(fin);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte_in    = 8'h00;
    src_idle_pct  = 0;
    snk_idle_pct  = 0;
    hold_off_reqs = 0;
    bytes_sent    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_bytes = '{lesp_pkg::CH_ESC, lesp_pkg::CH_LBRACKET, lesp_pkg::CH_Q, 8'hff,
                       lesp_pkg::CH_ESC, lesp_pkg::CH_LBRACKET, lesp_pkg::CH_ZERO + 8'd7,
                       lesp_pkg::CH_ZERO, lesp_pkg::CH_ZERO, lesp_pkg::CH_ZERO,
                       lesp_pkg::CH_ZERO, lesp_pkg::CH_P, lesp_pkg::CH_NL,
                       lesp_pkg::CH_ESC, lesp_pkg::CH_LBRACKET, lesp_pkg::CH_A,
                       lesp_pkg::CH_NL,
                       lesp_pkg::CH_ESC, lesp_pkg::CH_LBRACKET, lesp_pkg::CH_B,
                       lesp_pkg::CH_ESC, lesp_pkg::CH_LBRACKET, lesp_pkg::CH_ZERO + 8'd4,
                       lesp_pkg::CH_SEMI, lesp_pkg::CH_ZERO + 8'd5, lesp_pkg::CH_S};
    src_idle_pct = 25;
    snk_idle_pct = 70;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    run_random_phase(25, 70, 200);
    run_random_phase(70, 25, 200);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_off_reqs++;
    send_nest_run(lesp_pkg::CH_P, 257);
    run_random_phase(0, 0, 100);
    send_nest_run(lesp_pkg::CH_Q, 35);
    in_valid = 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
